/* design/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

	// Fixed field widths
	localparam int LEN_W      = 4;
	localparam int TEXT_W     = 64;
	localparam int CMD_BYTES  = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 8'd3;

	// Input item
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	// Result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
	} out_t;

	// Effective configuration seen by the front end
	typedef struct packed {
		logic [LEN_W-1:0]  plen;
		logic [TEXT_W-1:0] pattern;
		logic [LEN_W-1:0]  rlen;
		logic [TEXT_W-1:0] replacement;
	} cfg_t;

	// Emit command: up to eight bytes, oldest in data[0]
	typedef struct packed {
		logic [CMD_BYTES-1:0][7:0] data;
		logic [LEN_W-1:0]          count;
		logic                      last;
	} cmd_t;

endpackage

/* design/sfr_front.sv */
// Front end: holds the match window, classifies each byte and issues emit commands.
module sfr_front #(
	parameter int MAX_PATTERN = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sfr_pkg::in_t  in_data,
	input  sfr_pkg::cfg_t cfg,
	input  logic          clear,
	input  logic          q_full,
	output logic          q_push,
	output sfr_pkg::cmd_t q_cmd
);
	import sfr_pkg::*;

	localparam int PW = $clog2(MAX_PATTERN + 1);

	logic [MAX_PATTERN-1:0][7:0] win_q;
	logic [MAX_PATTERN-1:0][7:0] win_ins;
	logic [MAX_PATTERN-1:0][7:0] win_nxt;
	logic [PW-1:0]               fill_q;
	logic [PW-1:0]               fill_nxt;
	logic [PW-1:0]               fill_eff;
	logic [PW-1:0]               plen;
	logic [PW:0]                 fill_inc;
	logic                        accept;
	logic                        full;
	logic                        hit;

	assign plen     = cfg.plen[PW-1:0];
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign fill_eff = (fill_q >= plen) ? '0 : fill_q;
	assign fill_inc = {1'b0, fill_eff} + {{PW{1'b0}}, 1'b1};
	assign full     = (fill_inc == {1'b0, plen});

	// Insert the new byte and compare the window against the pattern
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_ins[i] = (PW'(i) == fill_eff) ? in_data.in_byte : win_q[i];
			if (PW'(i) < plen && win_ins[i] != cfg.pattern[8*i +: 8]) begin
				hit = 1'b0;
			end
		end
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			win_nxt[i] = win_ins[i+1];
		end
		win_nxt[MAX_PATTERN-1] = win_ins[MAX_PATTERN-1];
	end

	// Classify the step into a command and the next fill level
	always_comb begin
		q_cmd       = '0;
		q_cmd.last  = in_data.in_last;
		q_push      = 1'b0;
		fill_nxt    = fill_eff;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			q_cmd.data[i] = win_ins[i];
		end
		if (plen == '0) begin
			q_cmd.data[0] = in_data.in_byte;
			q_cmd.count   = LEN_W'(1);
			q_push        = 1'b1;
			fill_nxt      = '0;
		end else if (full && hit) begin
			q_cmd.data  = cfg.replacement;
			q_cmd.count = cfg.rlen;
			q_push      = (cfg.rlen != '0) || in_data.in_last;
			fill_nxt    = '0;
		end else if (in_data.in_last) begin
			q_cmd.count = LEN_W'(fill_inc);
			q_push      = 1'b1;
			fill_nxt    = '0;
		end else if (full) begin
			q_cmd.count = LEN_W'(1);
			q_push      = 1'b1;
			fill_nxt    = plen - PW'(1);
		end else begin
			fill_nxt    = fill_inc[PW-1:0];
		end
		q_push = q_push && accept;
	end

	// Advance the fill level; drop the window on a pattern length write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clear) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_nxt;
		end
	end

	// Hold the window bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= (full && !hit && !in_data.in_last) ? win_nxt : win_ins;
		end
	end

endmodule

/* design/sfr_queue.sv */
// Command queue between the front end and the emitter.
module sfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output sfr_pkg::cmd_t pop_cmd
);
	import sfr_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   count_q;

	assign full      = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = mem_q[rptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

endmodule

/* design/sfr_back.sv */
// Emitter: plays out queued commands one result per cycle while the output register is free.
module sfr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  sfr_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output sfr_pkg::out_t out_data
);
	import sfr_pkg::*;

	logic [CMD_BYTES-1:0][7:0] cur_data_q;
	logic [LEN_W-1:0]          cur_rem_q;
	logic                      cur_last_q;
	logic                      cur_vld_q;
	out_t                      od_q;
	logic                      ov_q;
	out_t                      od_nxt;
	logic                      out_free;
	logic                      emit;
	logic                      done;

	assign out_free  = !ov_q || out_ready;
	assign emit      = cur_vld_q && out_free;
	assign done      = emit && (cur_rem_q <= LEN_W'(1));
	assign q_pop     = q_valid && (!cur_vld_q || done);
	assign out_valid = ov_q;
	assign out_data  = od_q;

	// Form the next result; an empty command is a bare end marker
	always_comb begin
		if (cur_rem_q == '0) begin
			od_nxt.out_byte  = '0;
			od_nxt.out_valid = 1'b0;
			od_nxt.out_last  = 1'b1;
		end else begin
			od_nxt.out_byte  = cur_data_q[0];
			od_nxt.out_valid = 1'b1;
			od_nxt.out_last  = cur_last_q && (cur_rem_q == LEN_W'(1));
		end
	end

	// Track the current command and the output register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_vld_q <= 1'b1;
			end else if (done) begin
				cur_vld_q <= 1'b0;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Load or shift command payload; capture the output transfer
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_data_q <= q_cmd.data;
			cur_rem_q  <= q_cmd.count;
			cur_last_q <= q_cmd.last;
		end else if (emit) begin
			for (int i = 0; i < CMD_BYTES - 1; i++) begin
				cur_data_q[i] <= cur_data_q[i+1];
			end
			cur_rem_q <= cur_rem_q - LEN_W'(1);
		end
		if (emit) begin
			od_q <= od_nxt;
		end
	end

endmodule

/* design/stream_find_replace.sv */
// Stream find-and-replace over a byte stream, one input byte per transfer.
// Every non-overlapping, leftmost-first occurrence of the configured pattern is
// replaced by the replacement text; a byte marked last flushes the window and the
// last result carries out_last (a bare end marker if nothing else is emitted).
// Rate: one input byte per cycle while each byte yields at most one result and
// out_ready holds. A match emits replacement_length results and a flush emits
// the pending window, one result per cycle while out_ready holds, from the output
// register; the four-entry command queue absorbs such bursts and in_ready drops
// when it fills. Commands pass a current-command register. Configure only while
// idle; writing pattern_length discards pending bytes. cfg_ready is always high.
module stream_find_replace #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  sfr_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output sfr_pkg::out_t                     out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfr_pkg::TEXT_W-1:0]        cfg_data
);
	import sfr_pkg::*;

	logic [LEN_W-1:0]  plen_q;
	logic [TEXT_W-1:0] pattern_q;
	logic [LEN_W-1:0]  rlen_q;
	logic [TEXT_W-1:0] replacement_q;
	logic              cfg_wr;
	logic              clear;
	cfg_t              cfg;
	logic              q_full;
	logic              q_push;
	cmd_t              push_cmd;
	logic              q_pop;
	logic              q_valid;
	cmd_t              pop_cmd;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign clear     = cfg_wr && (cfg_index == REG_PATTERN_LENGTH);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q        <= '0;
			pattern_q     <= '0;
			rlen_q        <= '0;
			replacement_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_PATTERN_LENGTH:     plen_q        <= cfg_data[LEN_W-1:0];
				REG_PATTERN_BYTES:      pattern_q     <= cfg_data;
				REG_REPLACEMENT_LENGTH: rlen_q        <= cfg_data[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  replacement_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp lengths to the supported maxima
	always_comb begin
		cfg.plen        = (plen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_q;
		cfg.rlen        = (rlen_q > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT)
		                                                     : rlen_q;
		cfg.pattern     = pattern_q;
		cfg.replacement = replacement_q;
	end

	sfr_front #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.cfg     (cfg),
		.clear   (clear),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (push_cmd)
	);

	sfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_cmd  (pop_cmd)
	);

	sfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (pop_cmd),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

/* bench/tb_stream_find_replace.sv */
// Testbench for stream_find_replace: directed and random text streams checked against a predictor.
module tb_stream_find_replace;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	localparam int TIMEOUT_NS   = 2_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_PCT      = 23;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 36;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'd255;

	// Pattern and replacement lengths per random phase, extremes included
	localparam int PLEN_PLAN [PHASES] = '{2, 3, 1, 0, 8, 15, 4, 3, 5, 2, 6, 7};
	localparam int RLEN_PLAN [PHASES] = '{1, 3, 0, 2, 8, 15, 5, 0, 2, 7, 4, 9};

	// Predicts the rewritten text and holds the results still to come
	class text_rewrite_sb;
		logic [LEN_W-1:0]  plen_reg;
		logic [TEXT_W-1:0] pattern;
		logic [LEN_W-1:0]  rlen_reg;
		logic [TEXT_W-1:0] replacement;
		logic [7:0]        window [8];
		int                fill;
		out_t              expected_out [$];
		int                errors;

		function new();
			plen_reg    = '0;
			pattern     = '0;
			rlen_reg    = '0;
			replacement = '0;
			fill        = 0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TEXT_W-1:0] value);
			case (idx)
				REG_PATTERN_LENGTH: begin
					plen_reg = value[LEN_W-1:0];
					fill     = 0;
				end
				REG_PATTERN_BYTES:      pattern     = value;
				REG_REPLACEMENT_LENGTH: rlen_reg    = value[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  replacement = value;
				default: ;
			endcase
		endfunction

		function void emit(logic [7:0] b, logic v);
			out_t r;
			r.out_byte  = b;
			r.out_valid = v;
			r.out_last  = 1'b0;
			expected_out.push_back(r);
		endfunction

		// Work out the results caused by one accepted text byte
		function void take_byte(in_t item);
			int   plen;
			int   rlen;
			int   start;
			bit   hit;
			out_t r;
			plen  = (plen_reg > 4'd8) ? 8 : int'(plen_reg);
			rlen  = (rlen_reg > 4'd8) ? 8 : int'(rlen_reg);
			start = expected_out.size();
			if (plen == 0) begin
				fill = 0;
				emit(item.in_byte, 1'b1);
			end else begin
				if (fill >= plen)
					fill = 0;
				window[fill] = item.in_byte;
				fill++;
				// Full window: replace on a hit, else release the oldest byte
				if (fill == plen) begin
					hit = 1'b1;
					for (int i = 0; i < plen; i++)
						if (window[i] != pattern[8*i +: 8])
							hit = 1'b0;
					if (hit) begin
						for (int i = 0; i < rlen; i++)
							emit(replacement[8*i +: 8], 1'b1);
						fill = 0;
					end else begin
						emit(window[0], 1'b1);
						for (int i = 0; i < plen - 1; i++)
							window[i] = window[i+1];
						fill--;
					end
				end
				// Flush the pending window at end of text
				if (item.in_last) begin
					for (int i = 0; i < fill; i++)
						emit(window[i], 1'b1);
					fill = 0;
				end
			end
			// Close the text, with a bare end marker if nothing else went out
			if (item.in_last) begin
				if (expected_out.size() == start)
					emit(8'h00, 1'b0);
				r = expected_out.pop_back();
				r.out_last = 1'b1;
				expected_out.push_back(r);
			end
		endfunction

		function void check_output(out_t got);
			out_t want;
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected result byte=%h valid=%b last=%b", $time,
					got.out_byte, got.out_valid, got.out_last);
				errors++;
				return;
			end
			want = expected_out.pop_front();
			if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
			    got.out_last !== want.out_last) begin
				$display("%0t: mismatch expected byte=%h valid=%b last=%b, got byte=%h valid=%b last=%b",
					$time, want.out_byte, want.out_valid, want.out_last,
					got.out_byte, got.out_valid, got.out_last);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	in_t               in_data;
	logic              out_valid;
	logic              out_ready;
	out_t              out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TEXT_W-1:0] cfg_data;

	text_rewrite_sb book = new();
	int gap_pct  = IDLE_PCT;
	bit hold_out = 1'b0;

	stream_find_replace DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_output(out_data);
	end

	// Drive out_ready: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
			end
			out_ready <= (gap_pct == 0) || ($urandom_range(99) >= gap_pct);
		end
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("tb_stream_find_replace: errors");
		$finish;
	end

	function automatic in_t text_byte(logic [7:0] b, logic last);
		in_t item;
		item.in_byte = b;
		item.in_last = last;
		return item;
	endfunction

	task automatic send_byte(input in_t item);
		@(negedge clk);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		book.take_byte(item);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEXT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		book.write_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_rules(input logic [TEXT_W-1:0] plen, input logic [TEXT_W-1:0] pat,
	                         input logic [TEXT_W-1:0] rlen, input logic [TEXT_W-1:0] rep);
		write_reg(REG_PATTERN_LENGTH, plen);
		write_reg(REG_PATTERN_BYTES, pat);
		write_reg(REG_REPLACEMENT_LENGTH, rlen);
		write_reg(REG_REPLACEMENT_BYTES, rep);
	endtask

	// Drop in_valid and wait until every expected result has come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (book.expected_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Send texts built from the pattern, its prefixes and noise
	task automatic run_phase(input int plen, input int rlen, input int n_items);
		int         eff;
		int         na;
		int         made;
		int         len;
		int         r;
		int         cut;
		logic [7:0] alpha [3];
		logic [63:0] pat;
		in_t        text [$];
		in_t        item;
		eff  = (plen > 8) ? 8 : plen;
		na   = $urandom_range(1, 3);
		made = 0;
		for (int i = 0; i < 3; i++)
			alpha[i] = 8'($urandom_range(255));
		for (int i = 0; i < 8; i++)
			pat[8*i +: 8] = (i < eff) ? alpha[$urandom_range(na - 1)] : 8'($urandom_range(255));
		set_rules(64'(plen), pat, 64'(rlen), {$urandom, $urandom});
		while (made < n_items) begin
			text.delete();
			len = $urandom_range(1, 16);
			while (text.size() < len) begin
				r = $urandom_range(99);
				if (r < 30 && eff > 0) begin
					for (int i = 0; i < eff; i++)
						text.push_back(text_byte(pat[8*i +: 8], 1'b0));
				end else if (r < 45 && eff > 1) begin
					cut = $urandom_range(1, eff - 1);
					for (int i = 0; i < cut; i++)
						text.push_back(text_byte(pat[8*i +: 8], 1'b0));
				end else if (r < 55) begin
					text.push_back(text_byte(8'($urandom_range(255)), 1'b0));
				end else begin
					text.push_back(text_byte(alpha[$urandom_range(na - 1)], 1'b0));
				end
			end
			// Most texts end with a marked last byte; some run on into the next
			if ($urandom_range(9) != 0) begin
				item = text.pop_back();
				item.in_last = 1'b1;
				text.push_back(item);
			end
			foreach (text[i])
				send_byte(text[i]);
			made += text.size();
		end
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Pass-through straight out of reset
		send_byte(text_byte(8'h00, 1'b0));
		send_byte(text_byte(8'hFF, 1'b1));
		drain();

		// Unknown register index must leave the rules alone
		write_reg(REG_NONE, '1);

		// Three-byte pattern: a hit, a miss, then a flush on the last byte
		set_rules(64'd3, 64'hFFFF_FFFF_FF63_6261, 64'd2, 64'h0000_0000_0000_5958);
		send_byte(text_byte(8'h61, 1'b0));
		send_byte(text_byte(8'h62, 1'b0));
		send_byte(text_byte(8'h63, 1'b0));
		send_byte(text_byte(8'h61, 1'b0));
		send_byte(text_byte(8'h62, 1'b0));
		send_byte(text_byte(8'h64, 1'b0));
		send_byte(text_byte(8'h63, 1'b1));
		drain();

		// Empty replacement deletes the match; the text closes with a bare marker
		write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
		send_byte(text_byte(8'h61, 1'b0));
		send_byte(text_byte(8'h62, 1'b0));
		send_byte(text_byte(8'h63, 1'b1));
		drain();

		// Oversized lengths clamp to eight bytes
		set_rules('1, '1, 64'd15, 64'h0123_4567_89AB_CDEF);
		repeat (8) send_byte(text_byte(8'hFF, 1'b0));
		send_byte(text_byte(8'h00, 1'b1));
		drain();

		// Random phases; one long output hold-off and one stretch without gaps
		for (int p = 0; p < PHASES; p++) begin
			if (p == 4)
				hold_out = 1'b1;
			gap_pct = (p == 7) ? 0 : IDLE_PCT;
			run_phase(PLEN_PLAN[p], RLEN_PLAN[p], PHASE_ITEMS);
		end

		if (book.expected_out.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				book.expected_out.size());
			book.errors++;
		end
		if (book.errors == 0)
			$display("tb_stream_find_replace: clean");
		else
			$display("tb_stream_find_replace: errors");
		$finish;
	end

endmodule
